[rtl/core/sync_checksum_frame_receiver_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame receiver RTL.
// Both macros sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SYNC_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// condition must hold at every edge out of reset
`define SCFR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/scfr_pkg.sv]
// ---------------------------------------------------------------------------
// scfr_pkg
// Shared constants and types of the sync checksum frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

  // default frame length in bytes
  localparam int FRAME_LEN_DEFAULT = 32;

  // field widths
  localparam int DATA_W = 8;
  localparam int IDX_W  = 5;

  // reset value of the sync register
  localparam logic [DATA_W-1:0] SYNC_RESET = 8'hFF;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified byte handed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              is_sync;
  } q_item_t;

endpackage

`default_nettype wire

[rtl/core/scfr_ifs.sv]
// ---------------------------------------------------------------------------
// scfr_ifs
// Valid/ready channel interfaces: received bytes, emitted frame bytes and
// the sync register write port.
// ---------------------------------------------------------------------------
`default_nettype none

interface scfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_index;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_index, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                  output ready);
endinterface

interface scfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sync_value;

  modport source (output valid, output sync_value, input ready);
  modport sink   (input valid, input sync_value, output ready);
endinterface

`default_nettype wire

[rtl/core/sync_checksum_frame_receiver.sv]
// ---------------------------------------------------------------------------
// sync_checksum_frame_receiver
// Sync-byte framed receiver with an 8-bit additive checksum.
// ---------------------------------------------------------------------------
// Channels: rx takes one received byte per item, frame gives one verified
// frame byte per item with its position and a last flag, cfg writes the sync
// value (always ready, write only while the block is idle).
// Bytes pass a two-entry queue; the back takes one per cycle while it waits.
// Bytes before a sync byte are dropped. When the FRAME_LEN-th byte is stored,
// a scan reads positions 1 onward from the frame store RAM, summing and
// looking for a sync byte. On a match the frame leaves at one byte per cycle
// while the frame sink is ready, through the RAM read register and the output
// register. On a mismatch the tail from the first sync byte is copied to the
// front, one byte per cycle through the single RAM read port; with no sync
// byte found the store is emptied.
// A stalled frame sink holds the output register and the pending RAM read;
// bytes keep filling the queue until it is full, then rx.ready drops.
// Reset empties the store and queue and sets the sync value to 0xFF; the
// store contents need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_checksum_frame_receiver #(
  parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  scfr_cfg_if.sink     cfg,
  scfr_rx_if.sink      rx,
  scfr_frame_if.source frame
);

  logic              q_valid;
  logic              q_ready;
  scfr_pkg::q_item_t q_item;
  logic [7:0]        sync_value;

  // byte intake and classification
  scfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx         (rx),
    .sync_value (sync_value),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  // frame store and sequencer
  scfr_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .sync_value (sync_value),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .frame      (frame)
  );

endmodule

`default_nettype wire

[rtl/core/scfr_ram.sv]
// ---------------------------------------------------------------------------
// scfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/scfr_queue.sv]
// ---------------------------------------------------------------------------
// scfr_queue
// Short FIFO of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire scfr_pkg::q_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output scfr_pkg::q_item_t      out_item
);

  localparam int DEPTH = scfr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scfr_pkg::q_item_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/scfr_front.sv]
// ---------------------------------------------------------------------------
// scfr_front
// Holds the sync register, accepts received bytes, tags sync bytes and
// queues them for the back.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_front (
  input  wire logic         clk,
  input  wire logic         rst,
  scfr_cfg_if.sink          cfg,
  scfr_rx_if.sink           rx,
  output logic [7:0]        sync_value,
  output logic              q_valid,
  input  wire logic         q_ready,
  output scfr_pkg::q_item_t q_item
);

  scfr_pkg::q_item_t in_item;
  logic              in_ready;

  // sync register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= scfr_pkg::SYNC_RESET;
    end else if (cfg.valid) begin
      sync_value <= cfg.sync_value;
    end
  end

  // classify on entry
  assign in_item.data    = rx.rx_byte;
  assign in_item.is_sync = (rx.rx_byte == sync_value);
  assign rx.ready        = in_ready;

  scfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

endmodule

`default_nettype wire

[rtl/core/scfr_back.sv]
// ---------------------------------------------------------------------------
// scfr_back
// Frame store and sequencer: appends bytes, runs the checksum and sync scan,
// shifts a partial frame down, and emits verified frames.
// ---------------------------------------------------------------------------
`default_nettype none

module scfr_back #(
  parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        sync_value,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire scfr_pkg::q_item_t q_item,
  scfr_frame_if.source           frame
);

`include "sync_checksum_frame_receiver_defines.svh"

  localparam int AW = $clog2(FRAME_LEN);
  localparam int CW = $clog2(FRAME_LEN + 1);
  localparam logic [CW-1:0] LEN  = CW'(FRAME_LEN);
  localparam logic [CW-1:0] LAST = CW'(FRAME_LEN - 1);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_COPY = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] ptr;
  logic [CW-1:0] dst;
  logic [CW-1:0] rd_idx;
  logic          rd_valid;
  logic [7:0]    sum;
  logic [7:0]    byte1;
  logic          found;
  logic [CW-1:0] sync_pos;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic [4:0]    out_idx;
  logic          out_last;

  logic          take;
  logic          keep_byte;
  logic          issue;
  logic          load;
  logic          consumed;
  logic          hit;
  logic [7:0]    sum_fin;
  logic          found_fin;
  logic [CW-1:0] pos_fin;
  logic          rd_last;
  logic [CW+7:0] idx_wide;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // input side: one byte per cycle while idle
  assign q_ready   = (state == S_IDLE);
  assign take      = q_valid && q_ready;
  assign keep_byte = take && ((fill != '0) || q_item.is_sync);

  // read pipeline; in EMIT the read data waits until the output slot frees
  assign load     = (state == S_EMIT) && rd_valid && (!out_valid || frame.ready);
  assign consumed = rd_valid && ((state == S_SCAN) || (state == S_COPY) || load);
  assign rd_last  = (rd_idx == LAST);

  always_comb begin
    unique case (state)
      S_IDLE:         issue = 1'b0;
      S_SCAN, S_COPY: issue = (ptr < LEN);
      S_EMIT:         issue = (ptr < LEN) && (!rd_valid || load);
      default:        issue = 1'b0;
    endcase
  end

  // scan results including the byte arriving this cycle
  assign hit       = (ram_rdata == sync_value);
  assign sum_fin   = sum + ram_rdata;
  assign found_fin = found || hit;
  assign pos_fin   = found ? sync_pos : rd_idx;

  // store write port: appended bytes or shifted tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[AW-1:0];
    ram_wdata = q_item.data;
    if (state == S_IDLE) begin
      ram_we = keep_byte;
    end else if (state == S_COPY) begin
      ram_we    = rd_valid;
      ram_waddr = dst[AW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  scfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (keep_byte && (fill == LAST)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_valid && rd_last) begin
          if (sum_fin == byte1) begin
            state_next = S_EMIT;
          end else if (found_fin) begin
            state_next = S_COPY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_COPY: begin
        if (rd_valid && rd_last) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (load && rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // position masked to the index field
  assign idx_wide = {8'd0, rd_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // read issue and tracking
      if (issue) begin
        ptr    <= ptr + ONE;
        rd_idx <= ptr;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (consumed) begin
        rd_valid <= 1'b0;
      end

      // output register
      if (load) begin
        out_valid <= 1'b1;
        out_byte  <= ram_rdata;
        out_idx   <= idx_wide[4:0];
        out_last  <= rd_last;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (keep_byte) begin
            fill <= fill + ONE;
            if (fill == LAST) begin
              ptr   <= ONE;
              sum   <= '0;
              found <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (rd_valid) begin
            if (rd_idx == ONE) begin
              byte1 <= ram_rdata;
            end else begin
              sum <= sum_fin;
            end
            if (hit && !found) begin
              found    <= 1'b1;
              sync_pos <= rd_idx;
            end
            if (rd_last) begin
              if (sum_fin == byte1) begin
                fill <= '0;
                ptr  <= '0;
              end else if (found_fin) begin
                fill <= LEN - pos_fin;
                ptr  <= pos_fin;
                dst  <= '0;
              end else begin
                fill <= '0;
              end
            end
          end
        end
        S_COPY: begin
          if (rd_valid) begin
            dst <= dst + ONE;
          end
        end
        S_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.byte_index = out_idx;
  assign frame.last_byte  = out_last;

  // a partial frame never reaches the full length while waiting for bytes
  `SCFR_ASSERT_ALWAYS(a_fill_bound, (state != S_IDLE) || (fill < LEN), "fill count overflow")

  // the shift writes strictly below the position it reads
  `SCFR_ASSERT_ALWAYS(a_copy_order, (state != S_COPY) || !rd_valid || (dst < rd_idx),
    "copy destination overtook source")

  // a fetched frame byte waits intact while the output slot is busy
  `SCFR_ASSERT_NEXT(a_emit_hold, (state == S_EMIT) && rd_valid && !load,
    rd_valid && $stable(rd_idx) && $stable(ram_rdata), "pending frame byte lost")

endmodule

`default_nettype wire
